>>> hw/rtl/bmb_pkg.sv
// bmb_pkg: shared sizes, register indexes and widths for the block majority binarizer
// depends on nothing; imported by block_majority_binarizer
`timescale 1ns / 1ps

package bmb_pkg;

    // design limits
    localparam int MAX_BLOCKS_ACROSS = 128;
    localparam int MAX_BLOCK_SIZE    = 16;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int LEVEL_W    = 8;
    localparam int BSIZE_W    = 5;
    localparam int ACROSS_W   = 8;
    localparam int DOWN_W     = 12;
    localparam int BLOCK_ROW_W = 12;
    localparam int BLOCK_COL_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // derived internal widths
    localparam int CIB_W   = (MAX_BLOCK_SIZE > 1) ? $clog2(MAX_BLOCK_SIZE) : 1;
    localparam int BEFF_W  = $clog2(MAX_BLOCK_SIZE + 1);
    localparam int COL_W   = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
    localparam int AEFF_W  = $clog2(MAX_BLOCKS_ACROSS + 1);
    localparam int CNT_W   = $clog2(MAX_BLOCK_SIZE * MAX_BLOCK_SIZE + 1);
    localparam int AREA_W  = 2 * BEFF_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LEVEL     = 3'd0,
        REG_HIGH_LEVEL    = 3'd1,
        REG_BLOCK_SIZE    = 3'd2,
        REG_BLOCKS_ACROSS = 3'd3,
        REG_BLOCKS_DOWN   = 3'd4
    } t_reg_idx;

endpackage

>>> hw/rtl/block_majority_binarizer.sv
// block_majority_binarizer: per-block bright-pixel vote over a raster pixel stream
// depends on bmb_pkg
`timescale 1ns / 1ps

// Takes one grey pixel per cycle in raster order and, on the bottom right pixel of each
// square block, delivers one transfer with the block position, a vote bit (set when more
// than half of the block's pixels lie strictly above the midpoint of the low and high
// levels) and a flag on the final block of the image. Sustained rate is one pixel per
// clock while no held result stalls the input stage; the input stage feeds a result register.
// Counts live per column in a 128-entry memory with one write port and one registered
// read port; a bypass covers a read of the entry written in the same cycle. Entry valid
// bits make the memory read as zero after reset, so no clearing pass is needed. The user
// must write registers only while the block is idle; the block does not enforce it. A
// position that falls outside new bounds restarts at zero on the next pixel.
module block_majority_binarizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bmb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bmb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel stream
    input  logic                             i_pix_valid,
    output logic                             o_pix_ready,
    input  logic [bmb_pkg::PIX_W-1:0]        i_pixel,
    // block results
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [bmb_pkg::BLOCK_ROW_W-1:0]  o_block_row,
    output logic [bmb_pkg::BLOCK_COL_W-1:0]  o_block_col,
    output logic                             o_block_on,
    output logic                             o_frame_last
);
    import bmb_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0]  r_low_level;
    logic [LEVEL_W-1:0]  r_high_level;
    logic [BSIZE_W-1:0]  r_block_size;
    logic [ACROSS_W-1:0] r_blocks_across;
    logic [DOWN_W-1:0]   r_blocks_down;

    // position counters
    logic [CIB_W-1:0]  r_col_in_blk, n_col_in_blk;
    logic [CIB_W-1:0]  r_row_in_blk, n_row_in_blk;
    logic [COL_W-1:0]  r_blk_col,    n_blk_col;
    logic [DOWN_W-1:0] r_blk_row,    n_blk_row;

    // count memory and entry valid bits
    logic [CNT_W-1:0]             r_mem [MAX_BLOCKS_ACROSS];
    logic [MAX_BLOCKS_ACROSS-1:0] r_mem_vld;

    // input stage
    logic              r_s1_valid;
    logic              r_s1_bright;
    logic              r_s1_clear;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic [COL_W-1:0]  r_s1_addr;
    logic [DOWN_W-1:0] r_s1_row;
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_rd_ok;
    logic              r_byp_hit;
    logic [CNT_W-1:0]  r_byp_data;

    // result register
    logic                   r_out_valid;
    logic [BLOCK_ROW_W-1:0] r_out_row;
    logic [BLOCK_COL_W-1:0] r_out_col;
    logic                   r_out_on;
    logic                   r_out_last;

    // combinational signals
    logic [BEFF_W-1:0]  b_eff;
    logic [AEFF_W-1:0]  across_eff;
    logic [DOWN_W-1:0]  down_eff;
    logic [LEVEL_W:0]   level_sum;
    logic [LEVEL_W-1:0] threshold;
    logic [CIB_W-1:0]   cib, rib;
    logic [COL_W-1:0]   bci;
    logic [DOWN_W-1:0]  bri;
    logic [BEFF_W-1:0]  cib_inc, rib_inc;
    logic [AEFF_W-1:0]  bci_inc;
    logic [DOWN_W-1:0]  bri_inc;
    logic               col_end;
    logic               s0_clear, s0_emit, s0_last;
    logic               pix_xfer;
    logic               s1_adv;
    logic [CNT_W-1:0]   cnt_base, cnt_new;
    logic [AREA_W-1:0]  area;
    logic [CNT_W:0]     cnt_x2;

    // effective bounds from the registers
    always_comb begin
        if (r_block_size == '0) begin
            b_eff = BEFF_W'(1);
        end else if (32'(r_block_size) > MAX_BLOCK_SIZE) begin
            b_eff = BEFF_W'(MAX_BLOCK_SIZE);
        end else begin
            b_eff = BEFF_W'(r_block_size);
        end
        if (r_blocks_across == '0) begin
            across_eff = AEFF_W'(1);
        end else if (32'(r_blocks_across) > MAX_BLOCKS_ACROSS) begin
            across_eff = AEFF_W'(MAX_BLOCKS_ACROSS);
        end else begin
            across_eff = AEFF_W'(r_blocks_across);
        end
        down_eff  = (r_blocks_down == '0) ? DOWN_W'(1) : r_blocks_down;
        level_sum = {1'b0, r_low_level} + {1'b0, r_high_level};
        threshold = level_sum[LEVEL_W:1];
    end

    // handshake
    assign s1_adv      = r_s1_valid && (!r_s1_emit || !r_out_valid || i_res_ready);
    assign o_pix_ready = !r_s1_valid || s1_adv;
    assign pix_xfer    = i_pix_valid && o_pix_ready;
    assign o_cfg_ready = 1'b1;

    // position of the incoming pixel and the next position
    always_comb begin
        cib = (BEFF_W'(r_col_in_blk) >= b_eff) ? '0 : r_col_in_blk;
        rib = (BEFF_W'(r_row_in_blk) >= b_eff) ? '0 : r_row_in_blk;
        bci = (AEFF_W'(r_blk_col) >= across_eff) ? '0 : r_blk_col;
        bri = (r_blk_row >= down_eff) ? '0 : r_blk_row;

        cib_inc = BEFF_W'(cib) + BEFF_W'(1);
        rib_inc = BEFF_W'(rib) + BEFF_W'(1);
        bci_inc = AEFF_W'(bci) + AEFF_W'(1);
        bri_inc = bri + DOWN_W'(1);

        col_end  = (cib_inc >= b_eff);
        s0_clear = (rib == '0) && (cib == '0);
        s0_emit  = col_end && (rib_inc == b_eff);
        s0_last  = (bci_inc == across_eff) && (bri_inc == down_eff);

        n_col_in_blk = cib;
        n_row_in_blk = rib;
        n_blk_col    = bci;
        n_blk_row    = bri;
        if (col_end) begin
            n_col_in_blk = '0;
            if (bci_inc >= across_eff) begin
                n_blk_col = '0;
                if (rib_inc >= b_eff) begin
                    n_row_in_blk = '0;
                    n_blk_row    = (bri_inc >= down_eff) ? '0 : bri_inc;
                end else begin
                    n_row_in_blk = CIB_W'(rib_inc);
                end
            end else begin
                n_blk_col = COL_W'(bci_inc);
            end
        end else begin
            n_col_in_blk = CIB_W'(cib_inc);
        end
    end

    // count update and vote, saturating so the vote stays correct
    always_comb begin
        if (r_s1_clear) begin
            cnt_base = '0;
        end else if (r_byp_hit) begin
            cnt_base = r_byp_data;
        end else if (r_rd_ok) begin
            cnt_base = r_rd_data;
        end else begin
            cnt_base = '0;
        end
        cnt_new = (r_s1_bright && (cnt_base != '1)) ? cnt_base + CNT_W'(1) : cnt_base;
        area    = AREA_W'(b_eff) * AREA_W'(b_eff);
        cnt_x2  = {cnt_new, 1'b0};
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_level     <= '0;
            r_high_level    <= LEVEL_W'(255);
            r_block_size    <= BSIZE_W'(9);
            r_blocks_across <= ACROSS_W'(128);
            r_blocks_down   <= DOWN_W'(128);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LOW_LEVEL:     r_low_level     <= i_cfg_data[LEVEL_W-1:0];
                REG_HIGH_LEVEL:    r_high_level    <= i_cfg_data[LEVEL_W-1:0];
                REG_BLOCK_SIZE:    r_block_size    <= i_cfg_data[BSIZE_W-1:0];
                REG_BLOCKS_ACROSS: r_blocks_across <= i_cfg_data[ACROSS_W-1:0];
                REG_BLOCKS_DOWN:   r_blocks_down   <= i_cfg_data[DOWN_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters and stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in_blk <= '0;
            r_row_in_blk <= '0;
            r_blk_col    <= '0;
            r_blk_row    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mem_vld    <= '0;
        end else begin
            if (pix_xfer) begin
                r_col_in_blk <= n_col_in_blk;
                r_row_in_blk <= n_row_in_blk;
                r_blk_col    <= n_blk_col;
                r_blk_row    <= n_blk_row;
                r_s1_valid   <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid   <= 1'b0;
            end
            if (s1_adv) begin
                r_mem_vld[r_s1_addr] <= 1'b1;
            end
            if (s1_adv && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input stage payload, memory read with same-cycle write bypass
    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_s1_bright <= (i_pixel > threshold);
            r_s1_clear  <= s0_clear;
            r_s1_emit   <= s0_emit;
            r_s1_last   <= s0_last;
            r_s1_addr   <= bci;
            r_s1_row    <= bri;
            r_rd_data   <= r_mem[bci];
            r_rd_ok     <= r_mem_vld[bci];
            r_byp_hit   <= s1_adv && (r_s1_addr == bci);
            r_byp_data  <= cnt_new;
        end
    end

    // memory write
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= cnt_new;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_row  <= BLOCK_ROW_W'(r_s1_row);
            r_out_col  <= BLOCK_COL_W'(r_s1_addr);
            r_out_on   <= (AREA_W'(cnt_x2) > area) || (AREA_W < CNT_W + 1 &&
                          cnt_x2[CNT_W] && 1'b1);
            r_out_last <= r_s1_last;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_block_row  = r_out_row;
    assign o_block_col  = r_out_col;
    assign o_block_on   = r_out_on;
    assign o_frame_last = r_out_last;

    // stage never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_adv && r_s1_emit && r_out_valid && !i_res_ready))
        else $error("result register overwritten while stalled");

    // an accepted pixel occupies the input stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_xfer |=> r_s1_valid)
        else $error("accepted pixel lost from input stage");

    // a stalled stage keeps its item and address
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("stalled input stage changed");

    // a decided block appears at the output
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_emit) |=> o_res_valid)
        else $error("decided block not presented");

endmodule
